### sv/two_wire_segment_display_driver_macros.svh
// Assertion macros for the two-wire segment display driver.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef TWO_WIRE_SEGMENT_DISPLAY_DRIVER_MACROS_SVH
`define TWO_WIRE_SEGMENT_DISPLAY_DRIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TWSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TWSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/twsd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the segment encoder for the segment display driver.
// No dependencies.
package twsd_pkg;

  localparam int DigitCount = 4;

  localparam int ActionW   = 2;
  localparam int ValueW    = 14;
  localparam int PositionW = 2;
  localparam int DelayW    = 16;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 32;

  typedef enum logic [ActionW-1:0] {
    ActTick   = 2'd0,
    ActNumber = 2'd1,
    ActDigit  = 2'd2,
    ActBright = 2'd3
  } action_e;

  // Register index taken from paddr[CfgAddrW-1:2]
  localparam logic [CfgAddrW-3:0] RegDelay = '0;
  localparam logic [DelayW-1:0]   DelayReset = 16'd200;

  localparam logic [7:0] CmdWriteAuto  = 8'h40;
  localparam logic [7:0] CmdWriteFixed = 8'h44;
  localparam logic [7:0] CmdAddr       = 8'hC0;
  localparam logic [7:0] CmdDisplay    = 8'h88;

  // floor(x / 10) == (x * Div10Mul) >> Div10Shift for every 14-bit x
  localparam logic [ValueW-1:0] Div10Mul = 14'd13108;
  localparam int                Div10Shift = 17;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic busy_res;
    logic accepted;
  } res_t;

  function automatic logic [7:0] seg_encode(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0: seg = 8'h3f;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5b;
      4'd3: seg = 8'h4f;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6d;
      4'd6: seg = 8'h7d;
      4'd7: seg = 8'h07;
      4'd8: seg = 8'h7f;
      4'd9: seg = 8'h6f;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

### sv/twsd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command words in and line-level words out.
// Depends on twsd_pkg.
interface twsd_in_if;
  import twsd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ActionW-1:0]   action;
  logic [ValueW-1:0]    value;
  logic [PositionW-1:0] position;

  modport source(output valid, action, value, position, input ready);
  modport sink(input valid, action, value, position, output ready);
endinterface

interface twsd_out_if;
  logic valid;
  logic ready;
  logic clk_level;
  logic dio_level;
  logic busy_res;
  logic accepted;

  modport source(output valid, clk_level, dio_level, busy_res, accepted, input ready);
  modport sink(input valid, clk_level, dio_level, busy_res, accepted, output ready);
endinterface

### sv/two_wire_segment_display_driver.sv
`timescale 1ns / 1ps
// Two-wire seven-segment display driver. Every input word (tick or command) that is
// taken yields one output word with the clock/data line levels after it.
// The core takes one word per clock; a two-entry result queue lets it keep taking words
// while a result waits, so it stalls only when both entries are full. A show-number
// command splits its value into DIGIT_COUNT decimal digits in a divide-by-ten unit, one
// digit per clock, finished long before the first digit byte goes out on the wire.
// Line timing counts tick words: delay_ticks (APB register 0, reset 200) per period.
// Depends on twsd_pkg, twsd_if and the macros header.
`include "two_wire_segment_display_driver_macros.svh"

module two_wire_segment_display_driver #(
  parameter int DIGIT_COUNT = twsd_pkg::DigitCount
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  twsd_in_if.sink                       in_i,
  twsd_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twsd_pkg::CfgAddrW-1:0] paddr,
  input  logic [twsd_pkg::CfgDataW-1:0] pwdata,
  output logic [twsd_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import twsd_pkg::*;

  localparam int BufDepth = DIGIT_COUNT + 2;
  localparam int BufIdxW  = $clog2(BufDepth);
  localparam int ByteIdxW = $clog2(DIGIT_COUNT + 1);
  localparam int LenW     = $clog2(DIGIT_COUNT + 2);
  localparam logic [BufIdxW-1:0] DigFirst = BufIdxW'(DIGIT_COUNT + 1);
  localparam logic [BufIdxW-1:0] DigLast  = BufIdxW'(2);

  typedef enum logic [9:0] {
    PhIdle      = 10'b00_0000_0001,
    PhStartFall = 10'b00_0000_0010,
    PhBitData   = 10'b00_0000_0100,
    PhBitRise   = 10'b00_0000_1000,
    PhBitNext   = 10'b00_0001_0000,
    PhAckRise   = 10'b00_0010_0000,
    PhByteNext  = 10'b00_0100_0000,
    PhStopDio   = 10'b00_1000_0000,
    PhStopClk   = 10'b01_0000_0000,
    PhStopEnd   = 10'b10_0000_0000
  } phase_e;

  // ---------------- configuration ----------------
  logic [DelayW-1:0] delay_ticks_q;
  logic              cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[CfgAddrW-1:2] == RegDelay);
  assign prdata  = cfg_hit ? CfgDataW'(delay_ticks_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_ticks_q <= DelayReset;
    end else if (psel && penable && pwrite && cfg_hit) begin
      delay_ticks_q <= pwdata[DelayW-1:0];
    end
  end

  // ---------------- line sequencer ----------------
  phase_e              phase_q, phase_d;
  logic [DelayW-1:0]   delay_left_q, delay_left_d;
  logic [2:0]          bit_q, bit_d;
  logic [ByteIdxW-1:0] byte_q, byte_d;
  logic                frame_q, frame_d;
  logic [LenW-1:0]     len_q, len_d;
  logic                clk_q, clk_d;
  logic                dio_q, dio_d;

  logic [7:0]          byte_buf_q [BufDepth];
  logic [BufIdxW-1:0]  rd_idx;
  logic [7:0]          cur_byte;
  logic [DelayW-1:0]   delay_load;
  logic [DelayW-1:0]   delay_dec;
  logic                in_acc;
  logic                cmd_take;
  action_e             action;

  assign action     = action_e'(in_i.action);
  assign in_acc     = in_i.valid && in_i.ready;
  assign delay_load = (delay_ticks_q == '0) ? DelayW'(1) : delay_ticks_q;
  assign delay_dec  = (delay_left_q != '0) ? delay_left_q - DelayW'(1) : '0;
  assign rd_idx     = frame_q ? BufIdxW'(byte_q) + BufIdxW'(1) : '0;
  assign cur_byte   = byte_buf_q[rd_idx];

  always_comb begin
    phase_d      = phase_q;
    delay_left_d = delay_left_q;
    bit_d        = bit_q;
    byte_d       = byte_q;
    frame_d      = frame_q;
    len_d        = len_q;
    clk_d        = clk_q;
    dio_d        = dio_q;
    cmd_take     = 1'b0;
    if (in_acc) begin
      if (action == ActTick) begin
        if (phase_q != PhIdle) begin
          delay_left_d = delay_dec;
          if (delay_dec == '0) begin
            delay_left_d = delay_load;
            case (phase_q)
              PhStartFall: begin
                dio_d   = 1'b0;
                clk_d   = 1'b0;
                phase_d = PhBitData;
              end
              PhBitData: begin
                dio_d   = cur_byte[bit_q];
                phase_d = PhBitRise;
              end
              PhBitRise: begin
                clk_d   = 1'b1;
                phase_d = PhBitNext;
              end
              PhBitNext: begin
                clk_d = 1'b0;
                if (bit_q != 3'd7) begin
                  bit_d   = bit_q + 3'd1;
                  phase_d = PhBitData;
                end else begin
                  dio_d   = 1'b1;
                  phase_d = PhAckRise;
                end
              end
              PhAckRise: begin
                clk_d   = 1'b1;
                phase_d = PhByteNext;
              end
              PhByteNext: begin
                clk_d = 1'b0;
                if (frame_q && (LenW'(byte_q) + LenW'(1) < len_q)) begin
                  byte_d  = byte_q + ByteIdxW'(1);
                  bit_d   = '0;
                  phase_d = PhBitData;
                end else begin
                  phase_d = PhStopDio;
                end
              end
              PhStopDio: begin
                dio_d   = 1'b0;
                phase_d = PhStopClk;
              end
              PhStopClk: begin
                clk_d   = 1'b1;
                phase_d = PhStopEnd;
              end
              PhStopEnd: begin
                dio_d = 1'b1;
                if (!frame_q && len_q != '0) begin
                  // open the second frame right after the stop
                  frame_d = 1'b1;
                  clk_d   = 1'b1;
                  byte_d  = '0;
                  bit_d   = '0;
                  phase_d = PhStartFall;
                end else begin
                  phase_d      = PhIdle;
                  delay_left_d = '0;
                end
              end
              default: begin
                phase_d      = PhIdle;
                delay_left_d = '0;
              end
            endcase
          end
        end
      end else if (phase_q == PhIdle) begin
        cmd_take = 1'b1;
        case (action)
          ActNumber: len_d = LenW'(DIGIT_COUNT + 1);
          ActDigit:  len_d = LenW'(2);
          default:   len_d = '0;
        endcase
        frame_d      = 1'b0;
        dio_d        = 1'b1;
        clk_d        = 1'b1;
        byte_d       = '0;
        bit_d        = '0;
        delay_left_d = delay_load;
        phase_d      = PhStartFall;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      delay_left_q <= '0;
      bit_q        <= '0;
      byte_q       <= '0;
      frame_q      <= 1'b0;
      len_q        <= '0;
      clk_q        <= 1'b1;
      dio_q        <= 1'b1;
    end else begin
      phase_q      <= phase_d;
      delay_left_q <= delay_left_d;
      bit_q        <= bit_d;
      byte_q       <= byte_d;
      frame_q      <= frame_d;
      len_q        <= len_d;
      clk_q        <= clk_d;
      dio_q        <= dio_d;
    end
  end

  // ---------------- digit splitter ----------------
  // Peel off the low decimal digit each clock, filling the buffer from its last entry.
  logic [ValueW-1:0]   dig_val_q;
  logic [BufIdxW-1:0]  dig_idx_q;
  logic                dig_run_q;
  logic [2*ValueW-1:0] dig_prod;
  logic [ValueW-1:0]   dig_quo;
  logic [ValueW-1:0]   dig_rem;

  assign dig_prod = (2*ValueW)'(dig_val_q) * (2*ValueW)'(Div10Mul);
  assign dig_quo  = ValueW'(dig_prod >> Div10Shift);
  assign dig_rem  = dig_val_q - ((dig_quo << 3) + (dig_quo << 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_run_q <= 1'b0;
    end else if (cmd_take && action == ActNumber) begin
      dig_run_q <= 1'b1;
    end else if (dig_run_q && dig_idx_q == DigLast) begin
      dig_run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take && action == ActNumber) begin
      dig_val_q <= in_i.value;
      dig_idx_q <= DigFirst;
    end else if (dig_run_q) begin
      dig_val_q <= dig_quo;
      dig_idx_q <= dig_idx_q - BufIdxW'(1);
    end
  end

  // Byte buffer: command bytes on acceptance, digit segments from the splitter.
  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      case (action)
        ActNumber: begin
          byte_buf_q[0] <= CmdWriteAuto;
          byte_buf_q[1] <= CmdAddr;
        end
        ActDigit: begin
          byte_buf_q[0] <= CmdWriteFixed;
          byte_buf_q[1] <= CmdAddr | {6'b0, in_i.position};
          byte_buf_q[2] <= seg_encode(in_i.value[3:0]);
        end
        default: begin
          byte_buf_q[0] <= CmdDisplay | {5'b0, in_i.value[2:0]};
        end
      endcase
    end else if (dig_run_q) begin
      byte_buf_q[dig_idx_q] <= seg_encode(dig_rem[3:0]);
    end
  end

  // ---------------- result queue ----------------
  res_t       res_new;
  res_t       slot_q [2];
  logic [1:0] cnt_q;
  logic       pop;

  assign res_new = '{clk_level: clk_d, dio_level: dio_d,
                     busy_res: (phase_d != PhIdle), accepted: cmd_take};

  assign in_i.ready      = (cnt_q != 2'd2);
  assign out_o.valid     = (cnt_q != 2'd0);
  assign out_o.clk_level = slot_q[0].clk_level;
  assign out_o.dio_level = slot_q[0].dio_level;
  assign out_o.busy_res  = slot_q[0].busy_res;
  assign out_o.accepted  = slot_q[0].accepted;
  assign pop             = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (in_acc && !pop) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (pop && !in_acc) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (cnt_q == 2'd2) begin
        slot_q[0] <= slot_q[1];
      end else if (in_acc) begin
        slot_q[0] <= res_new;
      end
    end else if (in_acc) begin
      if (cnt_q == 2'd0) begin
        slot_q[0] <= res_new;
      end else begin
        slot_q[1] <= res_new;
      end
    end
  end

  // ---------------- assertions ----------------
  `TWSD_ASSERT_NOW(a_dig_busy, dig_run_q, phase_q != PhIdle, "digit split outside a command")
  `TWSD_ASSERT_NOW(a_dig_done, frame_q, !dig_run_q, "digit bytes not ready for second frame")
  `TWSD_ASSERT_NEXT(a_cmd_start, cmd_take, phase_q == PhStartFall && clk_q && dio_q, "command did not open a frame")
  `TWSD_ASSERT_NEXT(a_lines_hold, !in_acc, $stable(clk_q) && $stable(dio_q), "line moved without a word")

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the two-wire segment display driver: drives command and tick
// words, predicts the clock/data line levels of every word, and checks each output word.
// Depends on twsd_pkg, twsd_if and the driver RTL.
module tb_top;
  import twsd_pkg::*;

  localparam int CycleLimit   = 500000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 300;

  localparam logic [CfgAddrW-1:0] DelayAddr  = {RegDelay, 2'b00};
  localparam logic [CfgAddrW-1:0] UnusedAddr = {~RegDelay, 2'b00};
  localparam logic [7:0]          BrightMask = 8'h07;

  // segment codes, element d is the pattern for digit d; 10..15 are blank
  localparam logic [15:0][7:0] SegCode = {
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h6f, 8'h7f,
    8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };

  typedef enum logic [3:0] {
    LnIdle,
    LnStartFall,
    LnBitData,
    LnBitRise,
    LnBitNext,
    LnAckRise,
    LnByteNext,
    LnStopDio,
    LnStopClk,
    LnStopEnd
  } line_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  twsd_in_if  in_ch ();
  twsd_out_if out_ch ();

  two_wire_segment_display_driver i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // line sequencer state kept by the bench
  logic [DelayW-1:0] delay_cfg;
  line_phase_e       ln_phase;
  logic [DelayW-1:0] ln_left;
  logic [2:0]        ln_bit;
  int                ln_byte;
  logic              ln_frame;
  logic [7:0]        ln_buf [DigitCount+2];
  int                ln_second_len;
  logic              ln_clk;
  logic              ln_dio;

  res_t levels_q [$];
  int   errs = 0;
  int   words_sent = 0;
  int   words_checked = 0;
  int   cmds_taken = 0;
  int   cmds_dropped = 0;
  int   cycles = 0;
  logic steady = 1'b0;
  int   hold_req_id = 0;

  function automatic void arm_delay(line_phase_e nxt);
    ln_left  = (delay_cfg == '0) ? DelayW'(1) : delay_cfg;
    ln_phase = nxt;
  endfunction

  function automatic logic [7:0] cur_byte();
    int idx;
    idx = ln_frame ? 1 + ln_byte : 0;
    return ln_buf[idx];
  endfunction

  function automatic void frame_start();
    ln_dio  = 1'b1;
    ln_clk  = 1'b1;
    ln_byte = 0;
    ln_bit  = '0;
    arm_delay(LnStartFall);
  endfunction

  function automatic void line_advance();
    int flen;
    flen = ln_frame ? ln_second_len : 1;
    case (ln_phase)
      LnStartFall: begin
        ln_dio = 1'b0;
        ln_clk = 1'b0;
        arm_delay(LnBitData);
      end
      LnBitData: begin
        ln_dio = 1'(cur_byte() >> ln_bit);
        arm_delay(LnBitRise);
      end
      LnBitRise: begin
        ln_clk = 1'b1;
        arm_delay(LnBitNext);
      end
      LnBitNext: begin
        ln_clk = 1'b0;
        if (ln_bit != 3'd7) begin
          ln_bit++;
          arm_delay(LnBitData);
        end else begin
          // release data for the acknowledge clock
          ln_dio = 1'b1;
          arm_delay(LnAckRise);
        end
      end
      LnAckRise: begin
        ln_clk = 1'b1;
        arm_delay(LnByteNext);
      end
      LnByteNext: begin
        ln_clk = 1'b0;
        if (ln_byte + 1 < flen) begin
          ln_byte++;
          ln_bit = '0;
          arm_delay(LnBitData);
        end else begin
          arm_delay(LnStopDio);
        end
      end
      LnStopDio: begin
        ln_dio = 1'b0;
        arm_delay(LnStopClk);
      end
      LnStopClk: begin
        ln_clk = 1'b1;
        arm_delay(LnStopEnd);
      end
      LnStopEnd: begin
        ln_dio = 1'b1;
        if (!ln_frame && ln_second_len != 0) begin
          ln_frame = 1'b1;
          frame_start();
        end else begin
          ln_phase = LnIdle;
          ln_left  = '0;
        end
      end
      default: begin
        ln_phase = LnIdle;
        ln_left  = '0;
      end
    endcase
  endfunction

  // line levels after one input word
  function automatic res_t display_step(action_e act, logic [ValueW-1:0] v,
                                        logic [PositionW-1:0] pos);
    res_t        r;
    int unsigned scale;
    int unsigned num;
    logic        took;
    took = 1'b0;
    if (act == ActTick) begin
      if (ln_phase != LnIdle) begin
        if (ln_left != '0) ln_left--;
        if (ln_left == '0) line_advance();
      end
    end else if (ln_phase == LnIdle) begin
      took = 1'b1;
      cmds_taken++;
      case (act)
        ActNumber: begin
          num   = 32'(v);
          scale = 10 ** (DigitCount - 1);
          ln_buf[0] = CmdWriteAuto;
          ln_buf[1] = CmdAddr;
          // most significant digit first; a leading digit above 9 wraps
          for (int i = 0; i < DigitCount; i++) begin
            ln_buf[2+i] = SegCode[4'((num / scale) % 10)];
            scale = (scale / 10 == 0) ? 1 : scale / 10;
          end
          ln_second_len = DigitCount + 1;
        end
        ActDigit: begin
          ln_buf[0] = CmdWriteFixed;
          ln_buf[1] = CmdAddr | 8'(pos);
          ln_buf[2] = SegCode[v[3:0]];
          ln_second_len = 2;
        end
        default: begin
          ln_buf[0] = CmdDisplay | (v[7:0] & BrightMask);
          ln_second_len = 0;
        end
      endcase
      ln_frame = 1'b0;
      frame_start();
    end else begin
      cmds_dropped++;
    end
    r.clk_level = ln_clk;
    r.dio_level = ln_dio;
    r.busy_res  = (ln_phase != LnIdle);
    r.accepted  = took;
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // output side: check each word, then pick the next ready level
  int hold_ack_id = 0;
  int hold_left = 0;
  initial out_ch.ready = 1'b0;
  always @(posedge clk_i) begin : rx_side
    res_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (levels_q.size() == 0) begin
        $error("output word with nothing expected");
        errs++;
      end else begin
        e = levels_q.pop_front();
        words_checked++;
        if (out_ch.clk_level !== e.clk_level) begin
          $error("clk_level: expected %0b, got %0b", e.clk_level, out_ch.clk_level);
          errs++;
        end
        if (out_ch.dio_level !== e.dio_level) begin
          $error("dio_level: expected %0b, got %0b", e.dio_level, out_ch.dio_level);
          errs++;
        end
        if (out_ch.busy_res !== e.busy_res) begin
          $error("busy_res: expected %0b, got %0b", e.busy_res, out_ch.busy_res);
          errs++;
        end
        if (out_ch.accepted !== e.accepted) begin
          $error("accepted: expected %0b, got %0b", e.accepted, out_ch.accepted);
          errs++;
        end
      end
    end
    if (hold_req_id != hold_ack_id) begin
      hold_ack_id = hold_req_id;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 22);
    end
  end

  task automatic send_word(action_e act, logic [ValueW-1:0] v, logic [PositionW-1:0] pos);
    if (!steady && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    levels_q.push_back(display_step(act, v, pos));
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.value    <= v;
    in_ch.position <= pos;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // ticks carry random value and position, which the block must ignore
  task automatic send_tick();
    send_word(ActTick, ValueW'($urandom), PositionW'($urandom));
  endtask

  task automatic send_rand_cmd();
    action_e                act;
    logic [ValueW-1:0]      v;
    bit                     wide;
    act  = action_e'($urandom_range(1, 3));
    wide = ($urandom_range(9) < 3);
    case (act)
      ActNumber: v = wide ? ValueW'($urandom) : ValueW'($urandom_range(0, 9999));
      ActDigit:  v = wide ? ValueW'($urandom) : ValueW'($urandom_range(0, 9));
      default:   v = wide ? ValueW'($urandom) : ValueW'($urandom_range(0, 7));
    endcase
    send_word(act, v, PositionW'($urandom));
  endtask

  // tick the line back to idle, now and then slipping in a command that must be dropped
  task automatic run_to_idle(int drop_pct);
    while (ln_phase != LnIdle) begin
      if ($urandom_range(99) < drop_pct) send_rand_cmd();
      else send_tick();
    end
  endtask

  // drop valid and wait until every expected word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (levels_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr[CfgAddrW-1:2] == RegDelay) delay_cfg = data[DelayW-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= DelayAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[DelayW-1:0] !== delay_cfg) begin
      $error("delay_ticks: expected %0d, got %0d", delay_cfg, prdata[DelayW-1:0]);
      errs++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_idle_levels();
    repeat (12) send_tick();
    drain();
  endtask

  // first period at the reset delay of 200 ticks, then finish the frame at one tick per period
  task automatic test_default_delay();
    cfg_check();
    send_word(ActBright, ValueW'(5), '0);
    repeat (199) send_tick();
    drain();
    cfg_write(DelayAddr, 32'h0000_0001);
    cfg_check();
    run_to_idle(1);
    drain();
  endtask

  task automatic test_config_regs();
    cfg_write(UnusedAddr, 32'h0000_0011);
    cfg_check();
    // zero delay behaves like one tick per period
    cfg_write(DelayAddr, 32'hFFFF_0000);
    cfg_check();
  endtask

  task automatic test_commands();
    send_word(ActNumber, ValueW'(1234), 2'd2);
    run_to_idle(5);
    send_tick();
    send_word(ActNumber, '1, '0);
    run_to_idle(5);
    send_word(ActDigit, ValueW'(9), 2'd3);
    run_to_idle(5);
    send_word(ActDigit, '1, 2'd2);
    run_to_idle(5);
    send_word(ActBright, '1, 2'd1);
    run_to_idle(5);
    drain();
  endtask

  task automatic test_backpressure();
    cfg_write(DelayAddr, {16'hA5A5, 16'd1});
    cfg_check();
    hold_req_id++;
    send_word(ActDigit, ValueW'($urandom_range(0, 9)), PositionW'($urandom));
    repeat (60) send_tick();
    // sender stops mid-frame until everything is back
    drain();
    run_to_idle(5);
    drain();
  endtask

  task automatic test_random();
    int quota;
    for (int ph = 0; ph < 2; ph++) begin
      cfg_write(DelayAddr, CfgDataW'(2 - ph));
      cfg_check();
      steady = (ph == 1);
      quota  = words_sent + 60;
      while (words_sent < quota) begin
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) send_tick();
        send_rand_cmd();
        run_to_idle(5);
      end
      steady = 1'b0;
      drain();
    end
  endtask

  // largest delay: the line never gets far, only the counting is exercised
  task automatic test_max_delay();
    cfg_write(DelayAddr, 32'h0000_FFFF);
    cfg_check();
    send_word(ActNumber, ValueW'(8888), '0);
    repeat (60) begin
      if ($urandom_range(99) < 10) send_rand_cmd();
      else send_tick();
    end
    drain();
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.action   = ActTick;
    in_ch.value    = '0;
    in_ch.position = '0;
    delay_cfg      = DelayReset;
    ln_phase       = LnIdle;
    ln_left        = '0;
    ln_bit         = '0;
    ln_byte        = 0;
    ln_frame       = 1'b0;
    ln_second_len  = 0;
    ln_clk         = 1'b1;
    ln_dio         = 1'b1;
    foreach (ln_buf[i]) ln_buf[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_levels();
    test_default_delay();
    test_config_regs();
    test_commands();
    test_backpressure();
    test_random();
    test_max_delay();

    $display("Checked %0d output words for %0d input words at delays 0 to 65535.",
             words_checked, words_sent);
    $display("Commands taken: %0d, dropped while busy: %0d.", cmds_taken, cmds_dropped);
    if (errs == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
